// File: hdl/ufrb_pkg.sv
`timescale 1ns / 1ps

package ufrb_pkg;

  localparam int TX_ENTRIES = 16;
  localparam int RX_ENTRIES = 16;
  localparam int TX_PTR_W = $clog2(TX_ENTRIES);
  localparam int RX_PTR_W = $clog2(RX_ENTRIES);
  localparam int TX_LVL_W = $clog2(TX_ENTRIES + 1);
  localparam int RX_LVL_W = $clog2(RX_ENTRIES + 1);

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LIM_W     = 5;
  localparam int TICK_W    = 16;
  localparam int DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_LIMIT    = 2'd2;

  localparam logic [TICK_W-1:0] FRAME_TICKS_RST = 16'd16;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [7:0] ADDR_DATA   = 8'd0;
  localparam logic [7:0] ADDR_STATUS = 8'd4;
  localparam logic [7:0] ADDR_CTRL   = 8'd8;
  localparam logic [7:0] ADDR_LEVELS = 8'd12;
  localparam logic [7:0] ADDR_ERROR  = 8'd16;

  localparam int CTL_IRQ_RX  = 0;
  localparam int CTL_IRQ_TXE = 1;
  localparam int CTL_IRQ_ERR = 2;
  localparam int CTL_LOOP    = 3;

  typedef enum logic [1:0] {
    RESP_OK       = 2'd0,
    RESP_GENERIC  = 2'd1,
    RESP_CMD_ERR  = 2'd2,
    RESP_ADDR_ERR = 2'd3
  } resp_t;

  typedef enum logic [3:0] {
    OP_RD_DATA,
    OP_RD_STATUS,
    OP_RD_CTRL,
    OP_RD_LEVELS,
    OP_RD_ERROR,
    OP_WR_DATA,
    OP_WR_CTRL,
    OP_WR_ERROR,
    OP_CMD_ERR,
    OP_ADDR_ERR,
    OP_RX,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       sink_ready;
  } cmd_t;

endpackage

// File: hdl/ufrb_front.sv
`timescale 1ns / 1ps

module ufrb_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [7:0]                  in_address,
  input  logic [ufrb_pkg::DATA_W-1:0] in_write_data,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        in_sink_ready,
  input  logic                        q_full,
  output logic                        q_push,
  output ufrb_pkg::cmd_t              q_cmd
);
  import ufrb_pkg::*;

  op_t op;

  always_comb begin
    op = OP_TICK;
    case (in_req_type)
      REQ_READ: begin
        case (in_address)
          ADDR_DATA:   op = OP_RD_DATA;
          ADDR_STATUS: op = OP_RD_STATUS;
          ADDR_CTRL:   op = OP_RD_CTRL;
          ADDR_LEVELS: op = OP_RD_LEVELS;
          ADDR_ERROR:  op = OP_RD_ERROR;
          default:     op = OP_ADDR_ERR;
        endcase
      end
      REQ_WRITE: begin
        case (in_address)
          ADDR_DATA:   op = (|in_write_data[DATA_W-1:8]) ? OP_CMD_ERR : OP_WR_DATA;
          ADDR_CTRL:   op = (|in_write_data[DATA_W-1:4]) ? OP_CMD_ERR : OP_WR_CTRL;
          ADDR_ERROR:  op = (|in_write_data[DATA_W-1:1]) ? OP_CMD_ERR : OP_WR_ERROR;
          ADDR_STATUS: op = OP_CMD_ERR;
          ADDR_LEVELS: op = OP_CMD_ERR;
          default:     op = OP_ADDR_ERR;
        endcase
      end
      REQ_RX:   op = OP_RX;
      REQ_TICK: op = OP_TICK;
      default:  op = OP_TICK;
    endcase
  end

  assign q_cmd.op         = op;
  assign q_cmd.data       = (in_req_type == REQ_RX) ? in_rx_byte : in_write_data[7:0];
  assign q_cmd.sink_ready = in_sink_ready;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// File: hdl/ufrb_queue.sv
`timescale 1ns / 1ps

module ufrb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ufrb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ufrb_pkg::cmd_t head_cmd
);
  import ufrb_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full command queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid)) else $error("pop from empty command queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("command queue count out of range");

endmodule

// File: hdl/ufrb_back.sv
`timescale 1ns / 1ps

module ufrb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ufrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ufrb_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           q_valid,
  input  ufrb_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_response,
  output logic [ufrb_pkg::DATA_W-1:0]    out_read_data,
  output logic                           out_rx_taken,
  output logic                           out_tx_valid,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_irq
);
  import ufrb_pkg::*;

  logic [TICK_W-1:0]   frame_ticks_r;
  logic [TX_LVL_W-1:0] tx_lim_r;
  logic [RX_LVL_W-1:0] rx_lim_r;
  logic [LIM_W-1:0]    lim_raw;
  logic [TX_LVL_W-1:0] tx_lim_cfg;
  logic [RX_LVL_W-1:0] rx_lim_cfg;

  logic [8:0]          tx_store_r [TX_ENTRIES];
  logic [7:0]          rx_store_r [RX_ENTRIES];
  logic [TX_PTR_W-1:0] tx_head_r, tx_head_nxt;
  logic [TX_LVL_W-1:0] tx_level_r, tx_level_nxt;
  logic [RX_PTR_W-1:0] rx_head_r, rx_head_nxt;
  logic [RX_LVL_W-1:0] rx_level_r, rx_level_nxt;
  logic [3:0]          ctrl_r, ctrl_nxt;
  logic                ovr_r, ovr_nxt;
  logic [TICK_W-1:0]   timer_r, timer_nxt;

  logic                out_valid_r;
  resp_t               resp_r, resp_nxt;
  logic [DATA_W-1:0]   rdata_r, rdata_nxt;
  logic                taken_r, taken_nxt;
  logic                tvalid_r, tvalid_nxt;
  logic [7:0]          tbyte_r, tbyte_nxt;
  logic                irq_r, irq_nxt;

  logic                tx_full, rx_full;
  logic [TX_PTR_W-1:0] tx_tail;
  logic [RX_PTR_W-1:0] rx_tail;
  logic [8:0]          tx_front;
  logic                tx_push, tx_pop, rx_push, rx_pop;
  logic [8:0]          tx_push_val;
  logic [7:0]          rx_push_val;
  logic [TICK_W-1:0]   timer_inc;

  assign lim_raw = cfg_wdata[LIM_W-1:0];

  always_comb begin
    if (lim_raw == '0) begin
      tx_lim_cfg = TX_LVL_W'(1);
      rx_lim_cfg = RX_LVL_W'(1);
    end else begin
      tx_lim_cfg = (int'(lim_raw) > TX_ENTRIES) ? TX_LVL_W'(TX_ENTRIES) : TX_LVL_W'(lim_raw);
      rx_lim_cfg = (int'(lim_raw) > RX_ENTRIES) ? RX_LVL_W'(RX_ENTRIES) : RX_LVL_W'(lim_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ticks_r <= FRAME_TICKS_RST;
      tx_lim_r      <= TX_LVL_W'(TX_ENTRIES);
      rx_lim_r      <= RX_LVL_W'(RX_ENTRIES);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_TICKS: frame_ticks_r <= cfg_wdata[TICK_W-1:0];
        CFG_TX_LIMIT:    tx_lim_r      <= tx_lim_cfg;
        CFG_RX_LIMIT:    rx_lim_r      <= rx_lim_cfg;
        default:         ;
      endcase
    end
  end

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign tx_full   = (tx_level_r >= tx_lim_r);
  assign rx_full   = (rx_level_r >= rx_lim_r);
  assign tx_tail   = tx_head_r + tx_level_r[TX_PTR_W-1:0];
  assign rx_tail   = rx_head_r + rx_level_r[RX_PTR_W-1:0];
  assign tx_front  = tx_store_r[tx_head_r];
  assign timer_inc = (timer_r < frame_ticks_r) ? timer_r + TICK_W'(1) : timer_r;

  always_comb begin
    ctrl_nxt    = ctrl_r;
    ovr_nxt     = ovr_r;
    timer_nxt   = timer_r;
    tx_push     = 1'b0;
    tx_pop      = 1'b0;
    rx_push     = 1'b0;
    rx_pop      = 1'b0;
    tx_push_val = {ctrl_r[CTL_LOOP], q_cmd.data};
    rx_push_val = q_cmd.data;
    resp_nxt    = RESP_OK;
    rdata_nxt   = '0;
    taken_nxt   = 1'b0;
    tvalid_nxt  = 1'b0;
    tbyte_nxt   = '0;
    case (q_cmd.op)
      OP_RD_DATA: begin
        if (rx_level_r == '0) begin
          resp_nxt = RESP_GENERIC;
        end else begin
          rdata_nxt = DATA_W'(rx_store_r[rx_head_r]);
          rx_pop    = 1'b1;
        end
      end
      OP_RD_STATUS: rdata_nxt = DATA_W'({ovr_r, tx_level_r == '0, tx_full, rx_level_r != '0});
      OP_RD_CTRL:   rdata_nxt = DATA_W'(ctrl_r);
      OP_RD_LEVELS: rdata_nxt = {16'(tx_level_r), 16'(rx_level_r)};
      OP_RD_ERROR:  rdata_nxt = DATA_W'(ovr_r);
      OP_WR_DATA: begin
        if (tx_full) resp_nxt = RESP_GENERIC;
        else tx_push = 1'b1;
      end
      OP_WR_CTRL:  ctrl_nxt = q_cmd.data[3:0];
      OP_WR_ERROR: begin
        if (q_cmd.data[0]) ovr_nxt = 1'b0;
      end
      OP_CMD_ERR:  resp_nxt = RESP_CMD_ERR;
      OP_ADDR_ERR: resp_nxt = RESP_ADDR_ERR;
      OP_RX: begin
        if (rx_full) begin
          ovr_nxt = 1'b1;
        end else begin
          rx_push   = 1'b1;
          taken_nxt = 1'b1;
        end
      end
      OP_TICK: begin
        if (tx_level_r == '0) begin
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= frame_ticks_r) begin
            if (tx_front[8]) begin
              if (rx_full) ovr_nxt = 1'b1;
              else rx_push = 1'b1;
              rx_push_val = tx_front[7:0];
              tx_pop      = 1'b1;
            end else if (q_cmd.sink_ready) begin
              tvalid_nxt = 1'b1;
              tbyte_nxt  = tx_front[7:0];
              tx_pop     = 1'b1;
            end
            if (tx_pop) timer_nxt = '0;
          end
        end
      end
      default: ;
    endcase

    tx_head_nxt  = tx_pop ? tx_head_r + TX_PTR_W'(1) : tx_head_r;
    tx_level_nxt = tx_level_r + TX_LVL_W'(tx_push) - TX_LVL_W'(tx_pop);
    rx_head_nxt  = rx_pop ? rx_head_r + RX_PTR_W'(1) : rx_head_r;
    rx_level_nxt = rx_level_r + RX_LVL_W'(rx_push) - RX_LVL_W'(rx_pop);

    irq_nxt = (ctrl_nxt[CTL_IRQ_RX] && rx_level_nxt != '0) ||
              (ctrl_nxt[CTL_IRQ_TXE] && tx_level_nxt == '0) ||
              (ctrl_nxt[CTL_IRQ_ERR] && ovr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r   <= '0;
      tx_level_r  <= '0;
      rx_head_r   <= '0;
      rx_level_r  <= '0;
      ctrl_r      <= '0;
      ovr_r       <= 1'b0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        tx_head_r  <= tx_head_nxt;
        tx_level_r <= tx_level_nxt;
        rx_head_r  <= rx_head_nxt;
        rx_level_r <= rx_level_nxt;
        ctrl_r     <= ctrl_nxt;
        ovr_r      <= ovr_nxt;
        timer_r    <= timer_nxt;
      end
      if (q_pop) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      resp_r   <= resp_nxt;
      rdata_r  <= rdata_nxt;
      taken_r  <= taken_nxt;
      tvalid_r <= tvalid_nxt;
      tbyte_r  <= tbyte_nxt;
      irq_r    <= irq_nxt;
      if (tx_push) tx_store_r[tx_tail] <= tx_push_val;
      if (rx_push) rx_store_r[rx_tail] <= rx_push_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_response  = resp_r;
  assign out_read_data = rdata_r;
  assign out_rx_taken  = taken_r;
  assign out_tx_valid  = tvalid_r;
  assign out_tx_byte   = tbyte_r;
  assign out_irq       = irq_r;

  a_tx_level: assert property (@(posedge clk) disable iff (!rst_n)
    int'(tx_level_r) <= TX_ENTRIES) else $error("tx level above depth");
  a_rx_level: assert property (@(posedge clk) disable iff (!rst_n)
    int'(rx_level_r) <= RX_ENTRIES) else $error("rx level above depth");
  a_tx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tvalid_r) |-> (resp_r == RESP_OK && !taken_r && rdata_r == '0))
    else $error("serial send with bus result");
  a_timer_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && tx_pop) |=> (timer_r == '0)) else $error("frame timer not restarted");

endmodule

// File: hdl/uart_fifo_register_block.sv
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_stall  | req_type, address, write_data, rx_byte, sink_ready
// out      | out_valid/out_stall| response, read_data, rx_taken, tx_valid, tx_byte, irq
// cfg      | cfg_we             | cfg_index, cfg_wdata
//
// one transaction per cycle sustained while out_stall is low; result is registered
// (front decode into a two-entry command queue, then the back end output register)
// the back end state update and its output register are written in the same cycle
// synchronous active-low reset clears pointers, levels, control, timer, queue
// fifo entries are not cleared; out_stall holds the result and fills the queue

module uart_fifo_register_block (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [7:0]                     in_address,
  input  logic [ufrb_pkg::DATA_W-1:0]    in_write_data,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_sink_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_response,
  output logic [ufrb_pkg::DATA_W-1:0]    out_read_data,
  output logic                           out_rx_taken,
  output logic                           out_tx_valid,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_irq,
  input  logic                           cfg_we,
  input  logic [ufrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ufrb_pkg::CFG_W-1:0]     cfg_wdata
);
  import ufrb_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  ufrb_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_rx_byte    (in_rx_byte),
    .in_sink_ready (in_sink_ready),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  ufrb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  ufrb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_response  (out_response),
    .out_read_data (out_read_data),
    .out_rx_taken  (out_rx_taken),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_irq       (out_irq)
  );

endmodule

// File: test/uart_fifo_register_block_test.sv
`timescale 1ns / 1ps

module uart_fifo_register_block_test;
  import ufrb_pkg::*;

  typedef struct {
    logic [1:0]        req_type;
    logic [7:0]        address;
    logic [DATA_W-1:0] write_data;
    logic [7:0]        rx_byte;
    logic              sink_ready;
  } uart_req_t;

  typedef struct {
    resp_t             response;
    logic [DATA_W-1:0] read_data;
    logic              rx_taken;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              irq;
  } uart_res_t;

  typedef struct {
    logic [TICK_W-1:0] ticks;
    logic [LIM_W-1:0]  tx_lim;
    logic [LIM_W-1:0]  rx_lim;
  } uart_setting_t;

  localparam int TB_SLOTS = 1024;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = '0;
  logic [7:0]        in_address = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic [7:0]        in_rx_byte = '0;
  logic              in_sink_ready = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_response;
  logic [DATA_W-1:0] out_read_data;
  logic              out_rx_taken;
  logic              out_tx_valid;
  logic [7:0]        out_tx_byte;
  logic              out_irq;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  uart_fifo_register_block u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .in_rx_byte   (in_rx_byte),
    .in_sink_ready(in_sink_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_response (out_response),
    .out_read_data(out_read_data),
    .out_rx_taken (out_rx_taken),
    .out_tx_valid (out_tx_valid),
    .out_tx_byte  (out_tx_byte),
    .out_irq      (out_irq),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the uart state
  logic [8:0]        tx_mem [TX_ENTRIES];
  logic [7:0]        rx_mem [RX_ENTRIES];
  logic [TX_PTR_W-1:0] tx_head = '0;
  logic [RX_PTR_W-1:0] rx_head = '0;
  logic [TX_LVL_W-1:0] tx_level = '0;
  logic [RX_LVL_W-1:0] rx_level = '0;
  logic [3:0]        ctrl_bits = '0;
  logic              overrun = 1'b0;
  logic [TICK_W-1:0] frame_timer = '0;
  logic [TICK_W-1:0] frame_ticks = FRAME_TICKS_RST;
  logic [LIM_W-1:0]  tx_limit = 5'd16;
  logic [LIM_W-1:0]  rx_limit = 5'd16;

  uart_req_t   req_buf [TB_SLOTS];
  logic [9:0]  req_wr = '0;
  logic [9:0]  req_rd = '0;
  uart_res_t   res_buf [TB_SLOTS];
  logic [9:0]  res_wr = '0;
  logic [9:0]  res_rd = '0;
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatches = 0;
  logic        in_took = 1'b0;

  int unsigned send_wait = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;
  logic        long_hold_done = 1'b0;

  function automatic logic [LIM_W-1:0] limit_in_use(logic [LIM_W-1:0] lim, int depth);
    if (lim == 0) return LIM_W'(1);
    if (lim > depth) return depth[LIM_W-1:0];
    return lim;
  endfunction

  function automatic logic tx_is_full();
    return tx_level >= limit_in_use(tx_limit, TX_ENTRIES);
  endfunction

  function automatic logic rx_is_full();
    return rx_level >= limit_in_use(rx_limit, RX_ENTRIES);
  endfunction

  function automatic void rx_push(logic [7:0] b);
    logic [RX_PTR_W-1:0] slot;
    slot = rx_head + rx_level[RX_PTR_W-1:0];
    rx_mem[slot] = b;
    rx_level = rx_level + 1'b1;
  endfunction

  function automatic void tx_drop();
    tx_head = tx_head + 1'b1;
    tx_level = tx_level - 1'b1;
    frame_timer = '0;
  endfunction

  function automatic uart_res_t uart_model_step(uart_req_t r);
    uart_res_t           o;
    logic [8:0]          entry;
    logic [TX_PTR_W-1:0] slot;
    o.response  = RESP_OK;
    o.read_data = '0;
    o.rx_taken  = 1'b0;
    o.tx_valid  = 1'b0;
    o.tx_byte   = '0;
    case (r.req_type)
      REQ_READ: begin
        case (r.address)
          ADDR_DATA: begin
            if (rx_level == 0) begin
              o.response = RESP_GENERIC;
            end else begin
              o.read_data = {24'd0, rx_mem[rx_head]};
              rx_head = rx_head + 1'b1;
              rx_level = rx_level - 1'b1;
            end
          end
          ADDR_STATUS: o.read_data = {28'd0, overrun, tx_level == 0, tx_is_full(), rx_level != 0};
          ADDR_CTRL:   o.read_data = {28'd0, ctrl_bits};
          ADDR_LEVELS: o.read_data = {11'd0, tx_level, 11'd0, rx_level};
          ADDR_ERROR:  o.read_data = {31'd0, overrun};
          default:     o.response = RESP_ADDR_ERR;
        endcase
      end
      REQ_WRITE: begin
        case (r.address)
          ADDR_DATA: begin
            if (r.write_data > 255) begin
              o.response = RESP_CMD_ERR;
            end else if (tx_is_full()) begin
              o.response = RESP_GENERIC;
            end else begin
              slot = tx_head + tx_level[TX_PTR_W-1:0];
              tx_mem[slot] = {ctrl_bits[CTL_LOOP], r.write_data[7:0]};
              tx_level = tx_level + 1'b1;
            end
          end
          ADDR_CTRL: begin
            if (|r.write_data[DATA_W-1:4]) o.response = RESP_CMD_ERR;
            else ctrl_bits = r.write_data[3:0];
          end
          ADDR_ERROR: begin
            if (|r.write_data[DATA_W-1:1]) o.response = RESP_CMD_ERR;
            else if (r.write_data[0]) overrun = 1'b0;
          end
          ADDR_STATUS, ADDR_LEVELS: o.response = RESP_CMD_ERR;
          default: o.response = RESP_ADDR_ERR;
        endcase
      end
      REQ_RX: begin
        if (rx_is_full()) begin
          overrun = 1'b1;
        end else begin
          rx_push(r.rx_byte);
          o.rx_taken = 1'b1;
        end
      end
      default: begin
        if (tx_level == 0) begin
          frame_timer = '0;
        end else begin
          if (frame_timer < frame_ticks) frame_timer = frame_timer + 1'b1;
          if (frame_timer >= frame_ticks) begin
            entry = tx_mem[tx_head];
            if (entry[8]) begin
              if (rx_is_full()) overrun = 1'b1;
              else rx_push(entry[7:0]);
              tx_drop();
            end else if (r.sink_ready) begin
              o.tx_valid = 1'b1;
              o.tx_byte = entry[7:0];
              tx_drop();
            end
          end
        end
      end
    endcase
    o.irq = (ctrl_bits[CTL_IRQ_RX] && rx_level != 0) ||
            (ctrl_bits[CTL_IRQ_TXE] && tx_level == 0) ||
            (ctrl_bits[CTL_IRQ_ERR] && overrun);
    return o;
  endfunction

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic void queue_request(logic [1:0] kind, logic [7:0] addr,
                                        logic [DATA_W-1:0] wdata, logic [7:0] rbyte,
                                        logic ready);
    uart_req_t r;
    r.req_type   = kind;
    r.address    = addr;
    r.write_data = wdata;
    r.rx_byte    = rbyte;
    r.sink_ready = ready;
    req_buf[req_wr] = r;
    req_wr = req_wr + 10'd1;
    queued_count++;
  endfunction

  function automatic void queue_random_request();
    logic [7:0]        addr;
    logic [DATA_W-1:0] wdata;
    logic [7:0]        rbyte;
    logic              ready;
    int unsigned       pick;
    addr  = 8'($urandom);
    wdata = $urandom;
    rbyte = 8'($urandom);
    ready = ($urandom_range(0, 3) != 0);
    pick  = $urandom_range(0, 99);
    if (pick < 18) begin
      if ($urandom_range(0, 7) != 0) wdata = $urandom_range(0, 255);
      queue_request(REQ_WRITE, ADDR_DATA, wdata, rbyte, ready);
    end else if (pick < 34) begin
      queue_request(REQ_READ, ADDR_DATA, wdata, rbyte, ready);
    end else if (pick < 52) begin
      queue_request(REQ_TICK, addr, wdata, rbyte, ready);
    end else if (pick < 64) begin
      queue_request(REQ_RX, addr, wdata, rbyte, ready);
    end else if (pick < 73) begin
      case ($urandom_range(0, 3))
        0: addr = ADDR_STATUS;
        1: addr = ADDR_CTRL;
        2: addr = ADDR_LEVELS;
        default: addr = ADDR_ERROR;
      endcase
      queue_request(REQ_READ, addr, wdata, rbyte, ready);
    end else if (pick < 81) begin
      if ($urandom_range(0, 5) != 0) wdata = $urandom_range(0, 15);
      queue_request(REQ_WRITE, ADDR_CTRL, wdata, rbyte, ready);
    end else if (pick < 87) begin
      if ($urandom_range(0, 4) != 0) wdata = $urandom_range(0, 1);
      queue_request(REQ_WRITE, ADDR_ERROR, wdata, rbyte, ready);
    end else if (pick < 91) begin
      queue_request(REQ_WRITE, $urandom_range(0, 1) ? ADDR_STATUS : ADDR_LEVELS,
                    wdata, rbyte, ready);
    end else begin
      queue_request($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, addr, wdata, rbyte, ready);
    end
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result check, then acceptance of the offered transaction
  always @(posedge clk) begin
    uart_res_t want;
    uart_req_t got_req;
    if (rst_n && out_valid && !out_stall) begin
      if (res_wr == res_rd) begin
        mismatches++;
        $display("%0t: result expected none actual resp %0h data %0h", $time,
                 out_response, out_read_data);
      end else begin
        want = res_buf[res_rd];
        res_rd = res_rd + 10'd1;
        check_field("response", DATA_W'(want.response), DATA_W'(out_response));
        check_field("read_data", want.read_data, out_read_data);
        check_field("rx_taken", DATA_W'(want.rx_taken), DATA_W'(out_rx_taken));
        check_field("tx_valid", DATA_W'(want.tx_valid), DATA_W'(out_tx_valid));
        check_field("tx_byte", DATA_W'(want.tx_byte), DATA_W'(out_tx_byte));
        check_field("irq", DATA_W'(want.irq), DATA_W'(out_irq));
        checked_count++;
      end
    end
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      got_req.req_type   = in_req_type;
      got_req.address    = in_address;
      got_req.write_data = in_write_data;
      got_req.rx_byte    = in_rx_byte;
      got_req.sink_ready = in_sink_ready;
      res_buf[res_wr] = uart_model_step(got_req);
      res_wr = res_wr + 10'd1;
      accepted_count++;
    end
  end

  always @(negedge clk) begin
    uart_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_wait != 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (req_rd != req_wr) begin
        r = req_buf[req_rd];
        req_rd = req_rd + 10'd1;
        in_valid      <= 1'b1;
        in_req_type   <= r.req_type;
        in_address    <= r.address;
        in_write_data <= r.write_data;
        in_rx_byte    <= r.rx_byte;
        in_sink_ready <= r.sink_ready;
        if (send_calm != 0) begin
          send_calm--;
        end else begin
          send_wait = idle_span();
          if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with one long hold-off mid-stream so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!long_hold_done && accepted_count >= 300) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        stall_left = $urandom_range(64, 96);
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (recv_calm != 0) begin
        out_stall <= 1'b0;
        recv_calm--;
      end else begin
        stall_left = ($urandom_range(0, 2) == 0) ? idle_span() : 0;
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
        if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 60);
      end
    end
  end

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_FRAME_TICKS: frame_ticks = value;
      CFG_TX_LIMIT:    tx_limit = value[LIM_W-1:0];
      CFG_RX_LIMIT:    rx_limit = value[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input uart_setting_t s);
    write_setting(CFG_FRAME_TICKS, s.ticks);
    write_setting(CFG_TX_LIMIT, {11'd0, s.tx_lim});
    write_setting(CFG_RX_LIMIT, {11'd0, s.rx_lim});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (checked_count != queued_count) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    uart_setting_t plan [9];
    plan[0] = '{16'd0, 5'd1, 5'd1};
    plan[1] = '{16'd1, 5'd0, 5'd16};
    plan[2] = '{16'd3, 5'd31, 5'd0};
    plan[3] = '{16'd2, 5'd4, 5'd2};
    plan[4] = '{16'd65535, 5'd16, 5'd16};
    plan[5] = '{16'd1, 5'd17, 5'd5};
    plan[6] = '{16'd5, 5'd8, 5'd31};
    plan[7] = '{TICK_W'($urandom), LIM_W'($urandom_range(0, 31)),
                LIM_W'($urandom_range(0, 31))};
    plan[8] = '{TICK_W'($urandom_range(0, 12)), LIM_W'($urandom_range(0, 31)),
                LIM_W'($urandom_range(0, 31))};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_setting(CFG_FRAME_TICKS, 16'd0);
    @(negedge clk);
    cfg_we <= 1'b0;

    queue_request(REQ_READ, ADDR_DATA, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_READ, ADDR_STATUS, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    queue_request(REQ_WRITE, ADDR_CTRL, 32'h10, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_CTRL, 32'hF, 8'h00, 1'b0);
    queue_request(REQ_READ, ADDR_CTRL, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_DATA, 32'h100, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_DATA, 32'hFF, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_CTRL, 32'h7, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_DATA, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_READ, ADDR_LEVELS, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_STATUS, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_LEVELS, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_READ, 8'hFF, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_WRITE, 8'h03, 32'hFFFF_FFFF, 8'h00, 1'b0);
    queue_request(REQ_RX, 8'h00, 32'h0, 8'hA5, 1'b0);
    queue_request(REQ_TICK, 8'h00, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_TICK, 8'h00, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_TICK, 8'h00, 32'h0, 8'h00, 1'b1);
    queue_request(REQ_TICK, 8'h00, 32'h0, 8'h00, 1'b1);
    queue_request(REQ_READ, ADDR_DATA, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_READ, ADDR_DATA, 32'h0, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_ERROR, 32'hFFFF_FFFF, 8'h00, 1'b0);
    queue_request(REQ_WRITE, ADDR_ERROR, 32'h1, 8'h00, 1'b0);
    queue_request(REQ_READ, ADDR_ERROR, 32'h0, 8'h00, 1'b0);
    wait_idle();

    foreach (plan[i]) begin
      apply_setting(plan[i]);
      repeat (80) queue_random_request();
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("uart_fifo_register_block: match");
    end else begin
      $display("uart_fifo_register_block: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("uart_fifo_register_block: mismatch");
    $finish;
  end

endmodule

// File: uart_fifo_register_block.f
hdl/ufrb_pkg.sv
hdl/ufrb_front.sv
hdl/ufrb_queue.sv
hdl/ufrb_back.sv
hdl/uart_fifo_register_block.sv
test/uart_fifo_register_block_test.sv
